[rtl/lt_pkg.sv]
// Shared types and constants for the line tracer steering sequencer.
// Depends on nothing; used by lt_seq, lt_drive and the top level.
`default_nettype none

package lt_pkg;

  // Item kinds on the input channel.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CROSS_LOCKOUT = 3'd0,
    CFG_SETTLE        = 3'd1,
    CFG_PWM_PERIOD    = 3'd2,
    CFG_SERVO_MID     = 3'd3,
    CFG_SERVO_STEP    = 3'd4
  } lt_cfg_idx_t;

  // Register reset values.
  localparam logic [15:0] RST_CROSS_LOCKOUT = 16'd500;
  localparam logic [15:0] RST_SETTLE        = 16'd100;
  localparam logic [15:0] RST_PWM_PERIOD    = 16'd24575;
  localparam logic [11:0] RST_SERVO_MID     = 12'd2240;
  localparam logic [5:0]  RST_SERVO_STEP    = 6'd13;

  // Sensors that take part in normal tracing decisions.
  localparam logic [7:0] SENSOR_MASK = 8'hE7;

  // Largest 8-bit cross accumulation that is not a full crossline.
  localparam logic [7:0] CROSS_FULL_LIMIT = 8'hFD;

  // floor(x / 100) equals (x * RECIP_100) >> 30 for every x below 2**23.
  localparam logic [23:0] RECIP_100 = 24'd10737419;

  typedef enum logic [4:0] {
    MODE_TRACE  = 5'd0,
    MODE_HOLDL  = 5'd1,
    MODE_HOLDR  = 5'd2,
    MODE_XDET   = 5'd3,
    MODE_XCLS   = 5'd4,
    MODE_XWAIT  = 5'd5,
    MODE_XSLOW  = 5'd6,
    MODE_LPRE   = 5'd7,
    MODE_LTURN  = 5'd8,
    MODE_LEND   = 5'd9,
    MODE_RPRE   = 5'd10,
    MODE_RTURN  = 5'd11,
    MODE_REND   = 5'd12,
    MODE_RCWAIT = 5'd13,
    MODE_RCSLOW = 5'd14,
    MODE_RCEND  = 5'd15,
    MODE_LCWAIT = 5'd16,
    MODE_LCSLOW = 5'd17,
    MODE_LCEND  = 5'd18
  } lt_mode_t;

  // Steering command from the sequencer to the compare value datapath.
  // The angle is two's complement.
  typedef struct packed {
    logic        drive;
    logic [6:0]  angle;
    logic [6:0]  lpct;
    logic [6:0]  rpct;
    lt_mode_t    mode;
  } lt_cmd_t;

endpackage

`default_nettype wire

[rtl/lt_seq.sv]
// Steering sequencer: mode register, cross accumulator, settle and lockout counters.
// Depends on lt_pkg. Produces one lt_cmd_t per accepted item.
`default_nettype none

module lt_seq
  import lt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic        operation,
  input  wire logic [7:0]  sensor_bits,
  input  wire logic [15:0] cross_lockout_ms,
  input  wire logic [15:0] settle_ms,
  output lt_cmd_t          cmd
);

  lt_mode_t    mode_reg, mode_reg_next;
  logic [7:0]  cross_seen, cross_seen_next;
  logic        left_mark_seen, left_mark_seen_next;
  logic        right_mark_seen, right_mark_seen_next;
  logic [15:0] settle_count, settle_count_next;
  logic        lockout_active, lockout_active_next;
  logic [15:0] lockout_count, lockout_count_next;

  logic [7:0]  s;
  logic [7:0]  m;
  logic        is_sample;
  logic        cross_ok;
  logic        left_off;
  logic        right_off;
  logic        settled;
  logic        cls_full, cls_left, cls_right;
  logic        xslow_left, xslow_right;
  logic [7:0]  xdet_acc;
  logic        xdet_left, xdet_right;
  logic [15:0] lockout_inc;

  assign s         = sensor_bits;
  assign m         = sensor_bits & SENSOR_MASK;
  assign is_sample = (operation == OP_SAMPLE);
  assign cross_ok  = !lockout_active &&
                     (s == 8'hF8 || s == 8'h1F || s == 8'h0F || s == 8'h3F ||
                      s == 8'h7F || s == 8'hFF);
  assign left_off  = (m == 8'h04 || m == 8'h06 || m == 8'h07 || m == 8'h03);
  assign right_off = (m == 8'h20 || m == 8'h60 || m == 8'hE0 || m == 8'hC0);
  assign settled   = (settle_count > settle_ms);

  assign cls_full  = (cross_seen > CROSS_FULL_LIMIT);
  assign cls_left  = (cross_seen == 8'hFC || cross_seen == 8'hF8 || cross_seen == 8'hF0 ||
                      cross_seen == 8'h78 || cross_seen == 8'hE0);
  assign cls_right = (cross_seen == 8'h07 || cross_seen == 8'h0F || cross_seen == 8'h1F ||
                      cross_seen == 8'h1E || cross_seen == 8'h3F);

  assign xslow_left  = (s == 8'd240 || s == 8'd248 || s == 8'd224 || s == 8'd252);
  assign xslow_right = (s == 8'd15 || s == 8'd31 || s == 8'd7 || s == 8'd3);

  assign xdet_acc   = cross_seen | s;
  assign xdet_left  = left_mark_seen | s[5];
  assign xdet_right = right_mark_seen | s[2];

  assign lockout_inc = (lockout_count != 16'hFFFF) ? lockout_count + 16'd1 : lockout_count;

  // Next mode.
  always_comb begin
    mode_reg_next = mode_reg;
    if (step && is_sample) begin
      unique case (mode_reg)
        MODE_TRACE: begin
          if (cross_ok) begin
            mode_reg_next = MODE_XDET;
          end else if (m == 8'h03) begin
            mode_reg_next = MODE_HOLDL;
          end else if (m == 8'hC0) begin
            mode_reg_next = MODE_HOLDR;
          end
        end
        MODE_HOLDL: begin
          if (cross_ok) mode_reg_next = MODE_XDET;
          else if (m == 8'h06) mode_reg_next = MODE_TRACE;
        end
        MODE_HOLDR: begin
          if (cross_ok) mode_reg_next = MODE_XDET;
          else if (m == 8'h60) mode_reg_next = MODE_TRACE;
        end
        MODE_XDET: begin
          if ((xdet_left && !s[5]) || (xdet_right && !s[2])) mode_reg_next = MODE_XCLS;
        end
        MODE_XCLS: begin
          if (cls_full) mode_reg_next = MODE_XWAIT;
          else if (cls_left) mode_reg_next = MODE_LCWAIT;
          else if (cls_right) mode_reg_next = MODE_RCWAIT;
          else mode_reg_next = MODE_TRACE;
        end
        MODE_XWAIT:  if (settled) mode_reg_next = MODE_XSLOW;
        MODE_XSLOW: begin
          if (xslow_left) mode_reg_next = MODE_LPRE;
          else if (xslow_right) mode_reg_next = MODE_RPRE;
        end
        MODE_LPRE:   if (s == 8'd0) mode_reg_next = MODE_LTURN;
        MODE_LTURN: begin
          if (s == 8'd192 || s == 8'd64 || s == 8'd128) mode_reg_next = MODE_LEND;
        end
        MODE_LEND:   if (s == 8'h20) mode_reg_next = MODE_TRACE;
        MODE_RPRE:   if (s == 8'd0) mode_reg_next = MODE_RTURN;
        MODE_RTURN: begin
          if (s == 8'd3 || s == 8'd2 || s == 8'd1) mode_reg_next = MODE_REND;
        end
        MODE_REND:   if (s == 8'h04 || s == 8'h06) mode_reg_next = MODE_TRACE;
        MODE_RCWAIT: if (settled) mode_reg_next = MODE_RCSLOW;
        MODE_RCSLOW: if (s == 8'd0) mode_reg_next = MODE_RCEND;
        MODE_RCEND: begin
          if (s == 8'd32 || s == 8'd64 || s == 8'd96 || s == 8'd112 || s == 8'd192) begin
            mode_reg_next = MODE_TRACE;
          end
        end
        MODE_LCWAIT: if (settled) mode_reg_next = MODE_LCSLOW;
        MODE_LCSLOW: if (s == 8'd0) mode_reg_next = MODE_LCEND;
        MODE_LCEND: begin
          if (s == 8'd1 || s == 8'd2 || s == 8'd3 || s == 8'd4 || s == 8'd6 || s == 8'd7) begin
            mode_reg_next = MODE_TRACE;
          end
        end
        default: mode_reg_next = mode_reg;
      endcase
    end
  end

  // Steering command for the item.
  always_comb begin
    cmd.drive = 1'b0;
    cmd.angle = 7'sd0;
    cmd.lpct  = 7'd0;
    cmd.rpct  = 7'd0;
    cmd.mode  = mode_reg_next;
    if (is_sample) begin
      unique case (mode_reg)
        MODE_TRACE: begin
          if (!cross_ok) begin
            cmd.drive = 1'b1;
            unique case (m)
              8'h00: begin cmd.angle = 7'd0;            cmd.lpct = 7'd75; cmd.rpct = 7'd75; end
              8'h04: begin cmd.angle = 7'd5;            cmd.lpct = 7'd70; cmd.rpct = 7'd70; end
              8'h06: begin cmd.angle = 7'd18;           cmd.lpct = 7'd50; cmd.rpct = 7'd28; end
              8'h07: begin cmd.angle = 7'd23;           cmd.lpct = 7'd40; cmd.rpct = 7'd23; end
              8'h03: begin cmd.angle = 7'd29;           cmd.lpct = 7'd30; cmd.rpct = 7'd17; end
              8'h20: begin cmd.angle = 7'(-7'sd5);      cmd.lpct = 7'd70; cmd.rpct = 7'd70; end
              8'h60: begin cmd.angle = 7'(-7'sd18);     cmd.lpct = 7'd28; cmd.rpct = 7'd50; end
              8'hE0: begin cmd.angle = 7'(-7'sd23);     cmd.lpct = 7'd23; cmd.rpct = 7'd40; end
              8'hC0: begin cmd.angle = 7'(-7'sd29);     cmd.lpct = 7'd17; cmd.rpct = 7'd30; end
              default: cmd.drive = 1'b0;
            endcase
          end
        end
        MODE_XCLS: begin
          cmd.drive = cls_full || cls_left || cls_right;
        end
        MODE_XSLOW: begin
          if (!xslow_left && !xslow_right) begin
            if (m == 8'h00) begin
              cmd.drive = 1'b1; cmd.angle = 7'd0; cmd.lpct = 7'd35; cmd.rpct = 7'd35;
            end else if (left_off) begin
              cmd.drive = 1'b1; cmd.angle = 7'd3; cmd.lpct = 7'd30; cmd.rpct = 7'd30;
            end else if (right_off) begin
              cmd.drive = 1'b1; cmd.angle = 7'(-7'sd3); cmd.lpct = 7'd30; cmd.rpct = 7'd30;
            end
          end
        end
        MODE_LTURN: begin
          cmd.drive = 1'b1; cmd.angle = 7'(-7'sd40); cmd.lpct = 7'd0; cmd.rpct = 7'd35;
        end
        MODE_RTURN: begin
          cmd.drive = 1'b1; cmd.angle = 7'd47; cmd.lpct = 7'd51; cmd.rpct = 7'd0;
        end
        MODE_RCSLOW: begin
          if (s == 8'd0) begin
            cmd.drive = 1'b1; cmd.angle = 7'd20; cmd.lpct = 7'd40; cmd.rpct = 7'd31;
          end else if (m == 8'h00) begin
            cmd.drive = 1'b1; cmd.angle = 7'd0; cmd.lpct = 7'd30; cmd.rpct = 7'd30;
          end else if (left_off) begin
            cmd.drive = 1'b1; cmd.angle = 7'd8; cmd.lpct = 7'd35; cmd.rpct = 7'd30;
          end else if (right_off) begin
            cmd.drive = 1'b1; cmd.angle = 7'(-7'sd8); cmd.lpct = 7'd30; cmd.rpct = 7'd35;
          end
        end
        MODE_LCSLOW: begin
          if (s == 8'd0) begin
            cmd.drive = 1'b1; cmd.angle = 7'(-7'sd15); cmd.lpct = 7'd31; cmd.rpct = 7'd40;
          end else if (m == 8'h00) begin
            cmd.drive = 1'b1; cmd.angle = 7'd0; cmd.lpct = 7'd30; cmd.rpct = 7'd30;
          end else if (left_off) begin
            cmd.drive = 1'b1; cmd.angle = 7'd8; cmd.lpct = 7'd30; cmd.rpct = 7'd25;
          end else if (right_off) begin
            cmd.drive = 1'b1; cmd.angle = 7'(-7'sd8); cmd.lpct = 7'd25; cmd.rpct = 7'd30;
          end
        end
        default: cmd.drive = 1'b0;
      endcase
    end
  end

  // Cross accumulator, mark flags, settle and lockout counters.
  always_comb begin
    cross_seen_next      = cross_seen;
    left_mark_seen_next  = left_mark_seen;
    right_mark_seen_next = right_mark_seen;
    settle_count_next    = settle_count;
    lockout_active_next  = lockout_active;
    lockout_count_next   = lockout_count;
    if (step) begin
      if (!is_sample) begin
        if (settle_count != 16'hFFFF) settle_count_next = settle_count + 16'd1;
        if (lockout_active) begin
          lockout_count_next = lockout_inc;
          if (lockout_inc > cross_lockout_ms) lockout_active_next = 1'b0;
        end else begin
          lockout_count_next = 16'd0;
        end
      end else begin
        unique case (mode_reg)
          MODE_TRACE, MODE_HOLDL, MODE_HOLDR: begin
            if (cross_ok) begin
              cross_seen_next      = 8'd0;
              left_mark_seen_next  = 1'b0;
              right_mark_seen_next = 1'b0;
            end
          end
          MODE_XDET: begin
            cross_seen_next      = xdet_acc;
            left_mark_seen_next  = xdet_left;
            right_mark_seen_next = xdet_right;
          end
          MODE_XCLS: begin
            if (cls_full || cls_left || cls_right) settle_count_next = 16'd0;
          end
          MODE_XWAIT, MODE_RCWAIT, MODE_LCWAIT: begin
            if (settled) settle_count_next = 16'd0;
          end
          MODE_RCSLOW, MODE_LCSLOW: begin
            if (s == 8'd0) settle_count_next = 16'd0;
          end
          MODE_RCEND: begin
            if (s == 8'd32 || s == 8'd64 || s == 8'd96 || s == 8'd112 || s == 8'd192) begin
              lockout_active_next = 1'b1;
            end
          end
          MODE_LCEND: begin
            if (s == 8'd1 || s == 8'd2 || s == 8'd3 || s == 8'd4 || s == 8'd6 || s == 8'd7) begin
              lockout_active_next = 1'b1;
            end
          end
          default: cross_seen_next = cross_seen;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_TRACE;
      cross_seen      <= 8'd0;
      left_mark_seen  <= 1'b0;
      right_mark_seen <= 1'b0;
      settle_count    <= 16'd0;
      lockout_active  <= 1'b0;
      lockout_count   <= 16'd0;
    end else begin
      mode_reg        <= mode_reg_next;
      cross_seen      <= cross_seen_next;
      left_mark_seen  <= left_mark_seen_next;
      right_mark_seen <= right_mark_seen_next;
      settle_count    <= settle_count_next;
      lockout_active  <= lockout_active_next;
      lockout_count   <= lockout_count_next;
    end
  end

endmodule

`default_nettype wire

[rtl/lt_drive.sv]
// Compare value datapath: servo and motor compare values from a steering command.
// Depends on lt_pkg. Two register stages; the last one holds the values between commands.
`default_nettype none

module lt_drive
  import lt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        load_mul,
  input  wire logic        load_out,
  input  wire lt_cmd_t     cmd,
  input  wire logic [15:0] pwm_period,
  input  wire logic [11:0] servo_mid,
  input  wire logic [5:0]  servo_step,
  output logic [11:0]      servo_compare,
  output logic [15:0]      left_duty,
  output logic [15:0]      right_duty,
  output lt_mode_t         mode
);

  // Product stage.
  logic               mul_drive;
  lt_mode_t           mul_mode;
  logic signed [12:0] mul_servo;
  logic [22:0]        mul_left;
  logic [22:0]        mul_right;

  logic signed [13:0] servo_diff;
  logic [11:0]        servo_sat;
  logic [46:0]        left_scaled;
  logic [46:0]        right_scaled;

  always_ff @(posedge clk) begin
    if (load_mul) begin
      mul_drive <= cmd.drive;
      mul_mode  <= cmd.mode;
      mul_servo <= $signed({{6{cmd.angle[6]}}, cmd.angle}) * $signed({7'd0, servo_step});
      mul_left  <= {7'd0, pwm_period} * {16'd0, cmd.lpct};
      mul_right <= {7'd0, pwm_period} * {16'd0, cmd.rpct};
    end
  end

  // The servo value is clamped to the 12-bit compare range; the divide by
  // one hundred is a reciprocal multiply that is exact for 23-bit products.
  assign servo_diff   = $signed({2'b00, servo_mid}) - {mul_servo[12], mul_servo};
  assign left_scaled  = {24'd0, mul_left} * {23'd0, RECIP_100};
  assign right_scaled = {24'd0, mul_right} * {23'd0, RECIP_100};

  always_comb begin
    if (servo_diff < 14'sd0) begin
      servo_sat = 12'd0;
    end else if (servo_diff > 14'sd4095) begin
      servo_sat = 12'hFFF;
    end else begin
      servo_sat = servo_diff[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      servo_compare <= RST_SERVO_MID;
      left_duty     <= 16'd0;
      right_duty    <= 16'd0;
      mode          <= MODE_TRACE;
    end else if (load_out) begin
      mode <= mul_mode;
      if (mul_drive) begin
        servo_compare <= servo_sat;
        left_duty     <= left_scaled[45:30];
        right_duty    <= right_scaled[45:30];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/line_tracer_steering_fsm_core.sv]
// Top level of the line tracer steering sequencer with its configuration registers.
// Depends on lt_pkg, lt_seq and lt_drive.
`default_nettype none

// The block takes one beat per cycle on the input channel while in_ready is
// high: a sensor sample (operation 0, eight active-high line sensors) or a
// one-millisecond tick (operation 1). Every beat yields exactly one result
// beat carrying the held servo compare, the left and right motor compare
// values and the sequencer mode reached after that beat. The sequencer
// updates its state as the beat is taken and its command is registered, the
// next stage forms the angle-times-step and period-times-percent products, and
// the last stage clamps the servo value, divides the motor products by one
// hundred and updates the held outputs. The three stages advance independently,
// so a full pipeline sustains one beat per cycle while out_ready is high and
// empty stages absorb a stalled output. Configuration writes are taken at any
// time (cfg_ready is always high) but must only be issued while no beats are in
// flight; indexes beyond the register list are ignored. After reset the servo
// output holds the reset center value and both motor outputs are zero.
module line_tracer_steering_fsm_core
  import lt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        operation,
  input  wire logic [7:0]  sensor_bits,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      servo_compare,
  output logic [15:0]      left_duty,
  output logic [15:0]      right_duty,
  output logic [4:0]       mode,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] cross_lockout_ms;
  logic [15:0] settle_ms;
  logic [15:0] pwm_period;
  logic [11:0] servo_mid;
  logic [5:0]  servo_step;

  logic        accept;
  logic        cmd_valid, mul_valid;
  logic        cmd_en, mul_en, out_en;
  lt_cmd_t     seq_cmd;
  lt_cmd_t     cmd;
  lt_mode_t    mode_out;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cross_lockout_ms <= RST_CROSS_LOCKOUT;
      settle_ms        <= RST_SETTLE;
      pwm_period       <= RST_PWM_PERIOD;
      servo_mid        <= RST_SERVO_MID;
      servo_step       <= RST_SERVO_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CROSS_LOCKOUT: cross_lockout_ms <= cfg_data;
        CFG_SETTLE:        settle_ms        <= cfg_data;
        CFG_PWM_PERIOD:    pwm_period       <= cfg_data;
        CFG_SERVO_MID:     servo_mid        <= cfg_data[11:0];
        CFG_SERVO_STEP:    servo_step       <= cfg_data[5:0];
        default:           servo_step       <= servo_step;
      endcase
    end
  end

  // Each stage moves when it is empty or when the stage after it moves.
  assign out_en   = !out_valid || out_ready;
  assign mul_en   = !mul_valid || out_en;
  assign cmd_en   = !cmd_valid || mul_en;
  assign in_ready = cmd_en;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      mul_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_en) cmd_valid <= accept;
      if (mul_en) mul_valid <= cmd_valid;
      if (out_en) out_valid <= mul_valid;
    end
  end

  lt_seq u_seq (
    .clk              (clk),
    .rst              (rst),
    .step             (accept),
    .operation        (operation),
    .sensor_bits      (sensor_bits),
    .cross_lockout_ms (cross_lockout_ms),
    .settle_ms        (settle_ms),
    .cmd              (seq_cmd)
  );

  // Command register between the sequencer and the product stage.
  always_ff @(posedge clk) begin
    if (accept) cmd <= seq_cmd;
  end

  lt_drive u_drive (
    .clk           (clk),
    .rst           (rst),
    .load_mul      (cmd_valid && mul_en),
    .load_out      (mul_valid && out_en),
    .cmd           (cmd),
    .pwm_period    (pwm_period),
    .servo_mid     (servo_mid),
    .servo_step    (servo_step),
    .servo_compare (servo_compare),
    .left_duty     (left_duty),
    .right_duty    (right_duty),
    .mode          (mode_out)
  );

  assign mode = mode_out;

endmodule

`default_nettype wire

[tb/steer_check_pkg.sv]
// Scoreboard for the line tracer steering sequencer: a predictor of the held
// servo and motor compare values and the mode, plus the queue of results it expects.
// Depends on lt_pkg.
package steer_check_pkg;
  import lt_pkg::*;

  typedef struct packed {
    logic [11:0] servo;
    logic [15:0] left;
    logic [15:0] right;
    lt_mode_t    mode;
  } steer_t;

  class steer_predictor;
    logic [15:0] lockout_limit;
    logic [15:0] settle_limit;
    logic [15:0] period;
    logic [11:0] center;
    logic [5:0]  step;
    lt_mode_t    state;
    logic [7:0]  cross_acc;
    bit          left_mark;
    bit          right_mark;
    bit          lockout_on;
    logic [15:0] settle_cnt;
    logic [15:0] lockout_cnt;
    steer_t      hold;
    steer_t      expected_steer[$];
    int          mismatches;

    function new();
      lockout_limit = RST_CROSS_LOCKOUT;
      settle_limit  = RST_SETTLE;
      period        = RST_PWM_PERIOD;
      center        = RST_SERVO_MID;
      step          = RST_SERVO_STEP;
      state         = MODE_TRACE;
      cross_acc     = '0;
      left_mark     = 1'b0;
      right_mark    = 1'b0;
      lockout_on    = 1'b0;
      settle_cnt    = '0;
      lockout_cnt   = '0;
      hold.servo    = RST_SERVO_MID;
      hold.left     = '0;
      hold.right    = '0;
      hold.mode     = MODE_TRACE;
      mismatches    = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
        CFG_CROSS_LOCKOUT: lockout_limit = data;
        CFG_SETTLE:        settle_limit  = data;
        CFG_PWM_PERIOD:    period        = data;
        CFG_SERVO_MID:     center        = data[11:0];
        CFG_SERVO_STEP:    step          = data[5:0];
        default: ;
      endcase
    endfunction

    // Servo compare is center minus angle times step, clamped to 12 bits.
    function void set_drive(int angle, int lpct, int rpct);
      int v;
      v = int'(center) - angle * int'(step);
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      hold.servo = 12'(v);
      hold.left  = 16'((int'(period) * lpct) / 100);
      hold.right = 16'((int'(period) * rpct) / 100);
    endfunction

    function bit is_cross(logic [7:0] s);
      return s inside {8'hf8, 8'h1f, 8'h0f, 8'h3f, 8'h7f, 8'hff};
    endfunction

    function bit left_off(logic [7:0] m);
      return m inside {8'h04, 8'h06, 8'h07, 8'h03};
    endfunction

    function bit right_off(logic [7:0] m);
      return m inside {8'h20, 8'h60, 8'he0, 8'hc0};
    endfunction

    function void enter_cross();
      state      = MODE_XDET;
      cross_acc  = '0;
      left_mark  = 1'b0;
      right_mark = 1'b0;
    endfunction

    // Advances the predicted sequencer by one accepted input beat.
    function void take_beat(logic op, logic [7:0] s);
      logic [7:0] m;
      m = s & SENSOR_MASK;
      if (op == OP_TICK) begin
        if (settle_cnt != 16'hFFFF) settle_cnt++;
        if (lockout_on) begin
          if (lockout_cnt != 16'hFFFF) lockout_cnt++;
          if (lockout_cnt > lockout_limit) lockout_on = 1'b0;
        end else begin
          lockout_cnt = '0;
        end
      end else begin
        case (state)
          MODE_TRACE: begin
            if (!lockout_on && is_cross(s)) enter_cross();
            else begin
              case (m)
                8'h00: set_drive(0, 75, 75);
                8'h04: set_drive(5, 70, 70);
                8'h06: set_drive(18, 50, 28);
                8'h07: set_drive(23, 40, 23);
                8'h03: begin
                  set_drive(29, 30, 17);
                  state = MODE_HOLDL;
                end
                8'h20: set_drive(-5, 70, 70);
                8'h60: set_drive(-18, 28, 50);
                8'he0: set_drive(-23, 23, 40);
                8'hc0: begin
                  set_drive(-29, 17, 30);
                  state = MODE_HOLDR;
                end
                default: ;
              endcase
            end
          end
          MODE_HOLDL: begin
            if (!lockout_on && is_cross(s)) enter_cross();
            else if (m == 8'h06) state = MODE_TRACE;
          end
          MODE_HOLDR: begin
            if (!lockout_on && is_cross(s)) enter_cross();
            else if (m == 8'h60) state = MODE_TRACE;
          end
          MODE_XDET: begin
            cross_acc = cross_acc | s;
            if (s[5]) left_mark = 1'b1;
            if (s[2]) right_mark = 1'b1;
            if ((left_mark && !s[5]) || (right_mark && !s[2])) state = MODE_XCLS;
          end
          MODE_XCLS: begin
            if (cross_acc > CROSS_FULL_LIMIT) begin
              set_drive(0, 0, 0);
              state = MODE_XWAIT;
              settle_cnt = '0;
            end else if (cross_acc inside {8'hfc, 8'hf8, 8'hf0, 8'h78, 8'he0}) begin
              set_drive(0, 0, 0);
              state = MODE_LCWAIT;
              settle_cnt = '0;
            end else if (cross_acc inside {8'h07, 8'h0f, 8'h1f, 8'h1e, 8'h3f}) begin
              set_drive(0, 0, 0);
              state = MODE_RCWAIT;
              settle_cnt = '0;
            end else begin
              state = MODE_TRACE;
            end
          end
          MODE_XWAIT: begin
            if (settle_cnt > settle_limit) begin
              state = MODE_XSLOW;
              settle_cnt = '0;
            end
          end
          MODE_XSLOW: begin
            if (s inside {8'd240, 8'd248, 8'd224, 8'd252}) state = MODE_LPRE;
            else if (s inside {8'd15, 8'd31, 8'd7, 8'd3}) state = MODE_RPRE;
            else if (m == 8'h00) set_drive(0, 35, 35);
            else if (left_off(m)) set_drive(3, 30, 30);
            else if (right_off(m)) set_drive(-3, 30, 30);
          end
          MODE_LPRE: if (s == 8'h00) state = MODE_LTURN;
          MODE_LTURN: begin
            set_drive(-40, 0, 35);
            if (s inside {8'd192, 8'd64, 8'd128}) state = MODE_LEND;
          end
          MODE_LEND: if (s == 8'h20) state = MODE_TRACE;
          MODE_RPRE: if (s == 8'h00) state = MODE_RTURN;
          MODE_RTURN: begin
            set_drive(47, 51, 0);
            if (s inside {8'd3, 8'd2, 8'd1}) state = MODE_REND;
          end
          MODE_REND: if (s inside {8'h04, 8'h06}) state = MODE_TRACE;
          MODE_RCWAIT: begin
            if (settle_cnt > settle_limit) begin
              state = MODE_RCSLOW;
              settle_cnt = '0;
            end
          end
          MODE_RCSLOW: begin
            if (s == 8'h00) begin
              set_drive(20, 40, 31);
              state = MODE_RCEND;
              settle_cnt = '0;
            end else if (m == 8'h00) set_drive(0, 30, 30);
            else if (left_off(m)) set_drive(8, 35, 30);
            else if (right_off(m)) set_drive(-8, 30, 35);
          end
          MODE_RCEND: begin
            if (s inside {8'd32, 8'd64, 8'd96, 8'd112, 8'd192}) begin
              lockout_on = 1'b1;
              state = MODE_TRACE;
            end
          end
          MODE_LCWAIT: begin
            if (settle_cnt > settle_limit) begin
              state = MODE_LCSLOW;
              settle_cnt = '0;
            end
          end
          MODE_LCSLOW: begin
            if (s == 8'h00) begin
              set_drive(-15, 31, 40);
              state = MODE_LCEND;
              settle_cnt = '0;
            end else if (m == 8'h00) set_drive(0, 30, 30);
            else if (left_off(m)) set_drive(8, 30, 25);
            else if (right_off(m)) set_drive(-8, 25, 30);
          end
          MODE_LCEND: begin
            if (s inside {8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd7}) begin
              lockout_on = 1'b1;
              state = MODE_TRACE;
            end
          end
          default: ;
        endcase
      end
      hold.mode = state;
      expected_steer.push_back(hold);
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_steer(logic [11:0] servo, logic [15:0] left, logic [15:0] right,
                              logic [4:0] mode);
      steer_t want;
      if (expected_steer.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing expected: servo=%0d left=%0d %s",
                                servo, left, $sformatf("right=%0d mode=%0d", right, mode)));
        return;
      end
      want = expected_steer.pop_front();
      if (servo !== want.servo || left !== want.left || right !== want.right ||
          mode !== 5'(want.mode))
        flag_mismatch($sformatf("result mismatch: expected servo=%0d left=%0d right=%0d %s",
                                want.servo, want.left, want.right,
                                $sformatf("mode=%0d, got servo=%0d left=%0d right=%0d mode=%0d",
                                          want.mode, servo, left, right, mode)));
    endfunction
  endclass

endpackage

[tb/testbench.sv]
// Self-checking testbench for line_tracer_steering_fsm_core: sensor samples and
// millisecond ticks with random idling on both channels, checked beat by beat.
// Depends on lt_pkg, steer_check_pkg and the RTL of the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lt_pkg::*;
  import steer_check_pkg::*;

  // Generous bound: the slowest legal run, with every beat hit by the longest
  // gap on the sender and the longest stall on the receiver, stays well below it.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // A run of ticks long enough to show that an armed lockout with the largest
  // limit stays armed.
  localparam int unsigned LOCKOUT_TICKS = 40;

  // An index past the register list; the block must ignore writes to it.
  localparam logic [2:0] CFG_UNMAPPED = 3'd7;

  // Opening sequence at reset configuration: every tracing pattern, both curve
  // holds and their release, an unlisted pattern, a tick, and a full crossline
  // that clears the marks on entry and classifies into the crossline wait.
  localparam logic [8:0] OPENING [18] = '{
    {OP_SAMPLE, 8'h00}, {OP_SAMPLE, 8'h04}, {OP_SAMPLE, 8'h06}, {OP_SAMPLE, 8'h07},
    {OP_SAMPLE, 8'h20}, {OP_SAMPLE, 8'h60}, {OP_SAMPLE, 8'he0}, {OP_SAMPLE, 8'h03},
    {OP_SAMPLE, 8'h99}, {OP_SAMPLE, 8'h06}, {OP_SAMPLE, 8'hc0}, {OP_SAMPLE, 8'h60},
    {OP_SAMPLE, 8'h5a}, {OP_TICK,   8'h00}, {OP_SAMPLE, 8'hff}, {OP_SAMPLE, 8'hff},
    {OP_SAMPLE, 8'h00}, {OP_SAMPLE, 8'h00}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        operation;
  logic [7:0]  sensor_bits;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] servo_compare;
  logic [15:0] left_duty;
  logic [15:0] right_duty;
  logic [4:0]  mode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  steer_predictor steer_model;
  bit             idle_on;
  int             stall_left = 0;

  line_tracer_steering_fsm_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The run is cut off here if the block stops producing results.
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL");
    $finish;
  end

  // Result side. Outputs are sampled right at the edge, before any register
  // update of that edge lands, and out_ready is driven for the next edge.
  // While idling is on, the receiver stalls at random.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      steer_model.check_steer(servo_compare, left_duty, right_duty, mode);
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(4) == 0) stall_left = $urandom_range(1, 6);
    out_ready <= (stall_left == 0);
  end

  // Sends one input beat. The caller stands at a rising edge. An optional idle
  // gap goes first; then valid rises and holds with a stable payload until the
  // edge that accepts it, where the predictor takes the beat.
  task automatic send_beat(input logic op, input logic [7:0] s);
    int gap;
    if (idle_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    operation   <= op;
    sensor_bits <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    steer_model.take_beat(op, s);
  endtask

  // One configuration beat. cfg_valid stays high across back-to-back writes and
  // is lowered by the caller once the last one is taken.
  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    steer_model.write_reg(idx, data);
  endtask

  // Writes the whole register set plus one ignored index. Only called with no
  // beat in flight.
  task automatic configure(input logic [15:0] lockout, input logic [15:0] settle,
                           input logic [15:0] period, input logic [15:0] center,
                           input logic [15:0] step);
    write_reg(CFG_CROSS_LOCKOUT, lockout);
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_PWM_PERIOD, period);
    write_reg(CFG_SERVO_MID, center);
    write_reg(CFG_SERVO_STEP, step);
    write_reg(CFG_UNMAPPED, 16'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // The sender holds off until every expected result has been checked.
  task automatic drain();
    in_valid <= 1'b0;
    while (steer_model.expected_steer.size() != 0) @(posedge clk);
  endtask

  // Picks a sensor pattern that means something in the predicted mode, so that
  // random runs walk the crossline, crank and lane change sequences instead of
  // sitting in normal tracing.
  function automatic logic [7:0] useful_sensors();
    logic [7:0] pick[$];
    logic [7:0] extra;
    extra = 8'h00;
    case (steer_model.state)
      MODE_TRACE, MODE_HOLDL, MODE_HOLDR: begin
        pick = '{8'h00, 8'h04, 8'h06, 8'h07, 8'h03, 8'h20, 8'h60, 8'he0, 8'hc0,
                 8'hf8, 8'h1f, 8'h0f, 8'h3f, 8'h7f, 8'hff};
        // The two middle sensors do not take part in tracing decisions, but
        // they can turn an ordinary pattern into a crossline pattern.
        if ($urandom_range(2) == 0) extra = 8'($urandom) & ~SENSOR_MASK;
      end
      MODE_XDET: begin
        // Once something has been seen, an empty sample usually closes the
        // crossline so that the accumulated pattern stays classifiable.
        if (steer_model.cross_acc != 8'h00 && $urandom_range(99) < 60) return 8'h00;
        pick = '{8'h00, 8'hff, 8'hfe, 8'hf8, 8'hfc, 8'hf0, 8'h78, 8'he0,
                 8'h1f, 8'h0f, 8'h07, 8'h1e, 8'h3f};
      end
      MODE_XSLOW:
        pick = '{8'd240, 8'd248, 8'd224, 8'd252, 8'd15, 8'd31, 8'd7, 8'd3,
                 8'h00, 8'h04, 8'h06, 8'h20, 8'h60, 8'h18};
      MODE_LPRE, MODE_RPRE: pick = '{8'h00};
      MODE_LTURN:  pick = '{8'd192, 8'd64, 8'd128, 8'h00};
      MODE_LEND:   pick = '{8'h20};
      MODE_RTURN:  pick = '{8'd3, 8'd2, 8'd1, 8'h00};
      MODE_REND:   pick = '{8'h04, 8'h06};
      MODE_RCSLOW, MODE_LCSLOW:
        pick = '{8'h00, 8'h00, 8'h04, 8'h06, 8'h07, 8'h03, 8'h20, 8'h60, 8'he0,
                 8'hc0, 8'h18};
      MODE_RCEND:  pick = '{8'd32, 8'd64, 8'd96, 8'd112, 8'd192};
      MODE_LCEND:  pick = '{8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 8'd7};
      default: return 8'($urandom);
    endcase
    return pick[$urandom_range(pick.size() - 1)] | extra;
  endfunction

  // Random beats: ticks are frequent in the wait states and while the lockout
  // runs, most samples follow the predicted mode, and a tenth are pure noise.
  task automatic run_random(input int count, input bit stop_on_lockout);
    logic       op;
    logic [7:0] s;
    int         roll;
    int         tick_pct;
    for (int i = 0; i < count; i++) begin
      if (stop_on_lockout && steer_model.lockout_on) break;
      roll = $urandom_range(99);
      if (steer_model.state inside {MODE_XWAIT, MODE_RCWAIT, MODE_LCWAIT}) tick_pct = 70;
      else if (steer_model.lockout_on) tick_pct = 30;
      else tick_pct = 10;
      op = OP_SAMPLE;
      s  = 8'($urandom);
      if (roll < tick_pct) op = OP_TICK;
      else if (roll < 90) s = useful_sensors();
      send_beat(op, s);
    end
  endtask

  initial begin
    steer_model = new();
    idle_on     = 1'b1;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    operation   <= OP_SAMPLE;
    sensor_bits <= 8'h00;
    out_ready   <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_CROSS_LOCKOUT;
    cfg_data    <= 16'h0000;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: the directed opening, then random traffic. The
    // opening leaves the sequencer in the crossline wait with the reset settle
    // time, so the random part starts by counting ticks out of it.
    foreach (OPENING[i]) send_beat(OPENING[i][8], OPENING[i][7:0]);
    run_random(200, 1'b0);
    drain();

    // Upper extremes: the servo clamps at 4095 on left steering, and the motor
    // products use the full 16-bit period.
    configure(16'd3, 16'd2, 16'hFFFF, 16'd4095, 16'd63);
    run_random(150, 1'b0);
    drain();

    // Lower extremes, with no idling: the servo clamps at zero on right steering,
    // new motor values are always zero and the lockout ends on its first tick.
    idle_on <= 1'b0;
    configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd63);
    run_random(150, 1'b0);
    drain();

    // Zero step keeps the servo at center whatever the angle.
    idle_on <= 1'b1;
    configure(16'($urandom_range(0, 40)), 16'd1, 16'd1, 16'd2240, 16'd0);
    run_random(150, 1'b0);
    drain();

    // A lockout that never ends. Once a lane change has armed it, a
    // run of ticks leaves it armed; with the settle time at its maximum a wait
    // state is not left within the run.
    configure(16'hFFFF, 16'd2, 16'd24575, 16'd2240, 16'd13);
    run_random(250, 1'b1);
    drain();
    idle_on <= 1'b0;
    configure(16'hFFFF, 16'hFFFF, 16'd24575, 16'd2240, 16'd13);
    repeat (LOCKOUT_TICKS) send_beat(OP_TICK, 8'($urandom));
    run_random(60, 1'b0);
    drain();

    // Random settings. Short lockout and settle times keep the sequences moving;
    // upper bits of the center and step writes are random and must be dropped.
    idle_on <= 1'b1;
    repeat (3) begin
      configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 8)), 16'($urandom),
                16'($urandom), 16'($urandom));
      run_random(150, 1'b0);
      drain();
    end

    // Closing stretch at full rate on both sides.
    idle_on <= 1'b0;
    configure(16'($urandom_range(0, 40)), 16'($urandom_range(0, 8)), 16'($urandom),
              16'($urandom), 16'($urandom));
    run_random(200, 1'b0);
    drain();

    // A few more cycles so that any stray result beat gets caught.
    repeat (12) @(posedge clk);
    if (steer_model.mismatches == 0 && steer_model.expected_steer.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
